/* src/sbsc_pkg.sv */
// Shared types, constants and helpers for the swept box collision unit.
package sbsc_pkg;

   // Internal coordinate width in Q.8 units. It is wide enough for projected
   // end positions with the largest velocity, gravity and tick count.
   localparam int COORD_W = 32;
   localparam int NORM_W  = COORD_W + 1;
   localparam int PROD_W  = COORD_W + NORM_W;
   localparam int DOT_W   = PROD_W + 1;

   localparam int FIELD_W = 24;
   localparam int TICK_W  = 10;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [NORM_W-1:0]  norm_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [DOT_W-1:0]   dot_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } pt_type;

   typedef struct packed {
      coord_type lx;
      coord_type ly;
      coord_type hx;
      coord_type hy;
   } box_type;

   // Gravity modes.
   localparam logic [1:0] GRAV_NONE = 2'd0;
   localparam logic [1:0] GRAV_DOWN = 2'd1;
   localparam logic [1:0] GRAV_UP   = 2'd2;

   // Corner code per hull slot and sweep quadrant: bit 0 right edge, bit 1 bottom edge.
   localparam logic [1:0] CORNER_TAB [4][6] = '{
      '{2'd2, 2'd0, 2'd0, 2'd1, 2'd3, 2'd3},
      '{2'd0, 2'd1, 2'd1, 2'd3, 2'd2, 2'd2},
      '{2'd1, 2'd3, 2'd3, 2'd2, 2'd0, 2'd0},
      '{2'd3, 2'd2, 2'd2, 2'd0, 2'd1, 2'd1}
   };

   localparam coord_type SAT_MAX = coord_type'(8388607);
   localparam coord_type SAT_MIN = coord_type'(-8388608);

   function automatic pt_type corner_pt(box_type b, logic [1:0] code);
      pt_type p;
      p.x = code[0] ? b.hx : b.lx;
      p.y = code[1] ? b.hy : b.ly;
      return p;
   endfunction

endpackage

/* src/swept_box_sat_collision_unit.sv */
// Swept box collision unit: sweep projection, quick reject, hull axis test, bisection.
//
// One item in, one result beat out. On an accepted beat the unit projects the
// moving box's end position (with optional gravity from csr base_gravity),
// rejects at once when the bounding box of the sweep misses the fixed box,
// and otherwise builds the six-point hull of start and end boxes and runs a
// separating-axis test on the normal of each hull edge. On a hit the sweep is
// bisected BISECT_STEPS times and the top-left corner of the final start box
// is returned, saturated to signed 24 bits. Edges that only touch count as a
// hit; no hit returns zero coordinates. All projections go through one shared
// dot-product unit (two 32x33 multipliers and an adder), one vertex a cycle.
// An axis test loads the hull, then for each axis latches the normal, runs ten
// vertex projections, drains and compares, and it stops at the first separating
// axis. A quick reject skips the hull test; on a hit the test is run again
// once per bisection step.
// req_stall stays high while an item is in work; a finished result may wait
// in the output register while the next beat is accepted.
module swept_box_sat_collision_unit #(
   parameter int BISECT_STEPS = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [23:0]             csr_wr_data,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [23:0]      req_mover_x,
   input  logic signed [23:0]      req_mover_y,
   input  logic [23:0]             req_mover_w,
   input  logic [23:0]             req_mover_h,
   input  logic signed [23:0]      req_vel_x,
   input  logic signed [23:0]      req_vel_y,
   input  logic [9:0]              req_elapsed_ticks,
   input  logic [1:0]              req_gravity_mode,
   input  logic signed [23:0]      req_obstacle_x,
   input  logic signed [23:0]      req_obstacle_y,
   input  logic [23:0]             req_obstacle_w,
   input  logic [23:0]             req_obstacle_h,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_hit,
   output logic signed [23:0]      rsp_contact_x,
   output logic signed [23:0]      rsp_contact_y
);
   import sbsc_pkg::*;

   localparam int STEP_W = $clog2(BISECT_STEPS + 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_PRE1, ST_PRE2, ST_PRE3, ST_BOX, ST_REJ, ST_MID,
      ST_LOAD, ST_NORM, ST_DOT, ST_DRAIN, ST_EVAL, ST_DONE
   } state_type;

   state_type state_ff;

   logic [23:0]        gravity_ff;

   // latched item
   logic signed [23:0] px_ff, py_ff, vx_ff, vy_ff, ox_ff, oy_ff;
   logic [23:0]        w_ff, h_ff, ow_ff, oh_ff;
   logic [9:0]         t_ff;
   logic [1:0]         mode_ff;

   // projection
   logic signed [33:0] vxt_ff, vyt_ff;
   logic [33:0]        gt_ff;
   logic [43:0]        gtt_ff;
   logic signed [25:0] dx_ff;
   logic signed [29:0] dy_ff;

   // sweep boxes
   box_type            a_ff, b_ff, m_ff, o_ff;
   logic [1:0]         quad_ff;
   logic               bis_ff;
   logic [STEP_W-1:0]  step_ff;

   // axis test
   pt_type             hull_ff [6];
   logic [2:0]         edge_ff;
   logic [3:0]         vtx_ff;
   norm_type           nx_ff, ny_ff;
   prod_type           p1_ff, p2_ff;
   logic [3:0]         pk_ff;
   logic               pv_ff;
   dot_type            min1_ff, max1_ff, min2_ff, max2_ff;

   // pending and output result
   logic               res_hit_ff;
   logic signed [23:0] res_x_ff, res_y_ff;
   logic               rsp_valid_ff;
   logic               rsp_hit_ff;
   logic signed [23:0] rsp_x_ff, rsp_y_ff;

   // ---------------- combinational helpers ----------------
   logic signed [45:0] dy_num;
   box_type            cand_box;
   pt_type             hull_new [6];
   pt_type             h0_pt, h3_pt;
   logic signed [COORD_W:0] mid_sx, mid_sy;
   coord_type          mid_x, mid_y;
   coord_type          half_w, half_h;
   pt_type             edge_p, edge_n, vtx_pt;
   logic [2:0]         edge_next;
   dot_type            dot_val;
   logic               reject, separated;
   coord_type          minx, maxx, miny, maxy;
   coord_type          sat_x, sat_y;

   always_comb begin
      dy_num = 46'(vyt_ff) <<< 8;
      case (mode_ff)
         GRAV_DOWN: dy_num = dy_num + $signed({2'b00, gtt_ff});
         GRAV_UP:   dy_num = dy_num - $signed({2'b00, gtt_ff});
         default:   dy_num = dy_num;
      endcase
   end

   // Candidate end box: the full sweep for the first test, the midpoint box while bisecting.
   assign cand_box = bis_ff ? m_ff : b_ff;

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         hull_new[i] = corner_pt((i >= 2 && i <= 4) ? cand_box : a_ff, CORNER_TAB[quad_ff][i]);
      end
   end

   assign h0_pt  = corner_pt(a_ff, CORNER_TAB[quad_ff][0]);
   assign h3_pt  = corner_pt(b_ff, CORNER_TAB[quad_ff][3]);
   assign mid_sx = (COORD_W+1)'(h0_pt.x) + (COORD_W+1)'(h3_pt.x);
   assign mid_sy = (COORD_W+1)'(h0_pt.y) + (COORD_W+1)'(h3_pt.y);
   assign mid_x  = coord_type'(mid_sx >>> 1);
   assign mid_y  = coord_type'(mid_sy >>> 1);
   assign half_w = coord_type'({1'b0, w_ff[23:1]});
   assign half_h = coord_type'({1'b0, h_ff[23:1]});

   assign edge_next = (edge_ff == 3'd5) ? 3'd0 : edge_ff + 3'd1;
   assign edge_p    = hull_ff[edge_ff];
   assign edge_n    = hull_ff[edge_next];

   // Vertex feed: six hull points, then the four fixed box corners.
   assign vtx_pt = (vtx_ff < 4'd6) ? hull_ff[vtx_ff[2:0]]
                                   : corner_pt(o_ff, 2'(vtx_ff - 4'd6));

   assign dot_val   = DOT_W'(p1_ff) + DOT_W'(p2_ff);
   assign separated = (max1_ff < min2_ff) || (min1_ff > max2_ff);

   always_comb begin
      minx = (a_ff.lx < b_ff.lx) ? a_ff.lx : b_ff.lx;
      maxx = (a_ff.hx > b_ff.hx) ? a_ff.hx : b_ff.hx;
      miny = (a_ff.ly < b_ff.ly) ? a_ff.ly : b_ff.ly;
      maxy = (a_ff.hy > b_ff.hy) ? a_ff.hy : b_ff.hy;
      reject = (maxy < o_ff.ly) || (miny > o_ff.hy) || (maxx < o_ff.lx) || (minx > o_ff.hx);
   end

   always_comb begin
      sat_x = a_ff.lx;
      sat_y = a_ff.ly;
      if (a_ff.lx > SAT_MAX) sat_x = SAT_MAX;
      if (a_ff.lx < SAT_MIN) sat_x = SAT_MIN;
      if (a_ff.ly > SAT_MAX) sat_y = SAT_MAX;
      if (a_ff.ly < SAT_MIN) sat_y = SAT_MIN;
   end

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gravity_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         pv_ff        <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            gravity_ff <= csr_wr_data;
         end

         // Load the output register when a result is ready and the register is free,
         // drop valid once the beat is taken.
         if (state_ff == ST_DONE && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         // Accumulate one registered projection into the running bounds.
         pv_ff <= (state_ff == ST_DOT);
         if (pv_ff) begin
            if (pk_ff < 4'd6) begin
               if (pk_ff == 4'd0 || dot_val < min1_ff) min1_ff <= dot_val;
               if (pk_ff == 4'd0 || dot_val > max1_ff) max1_ff <= dot_val;
            end else begin
               if (pk_ff == 4'd6 || dot_val < min2_ff) min2_ff <= dot_val;
               if (pk_ff == 4'd6 || dot_val > max2_ff) max2_ff <= dot_val;
            end
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  px_ff   <= req_mover_x;
                  py_ff   <= req_mover_y;
                  w_ff    <= req_mover_w;
                  h_ff    <= req_mover_h;
                  vx_ff   <= req_vel_x;
                  vy_ff   <= req_vel_y;
                  t_ff    <= req_elapsed_ticks;
                  mode_ff <= req_gravity_mode;
                  ox_ff   <= req_obstacle_x;
                  oy_ff   <= req_obstacle_y;
                  ow_ff   <= req_obstacle_w;
                  oh_ff   <= req_obstacle_h;
                  state_ff <= ST_PRE1;
               end
            end
            ST_PRE1: begin
               vxt_ff   <= 34'(vx_ff) * $signed({24'd0, t_ff});
               vyt_ff   <= 34'(vy_ff) * $signed({24'd0, t_ff});
               gt_ff    <= 34'(gravity_ff) * 34'(t_ff);
               state_ff <= ST_PRE2;
            end
            ST_PRE2: begin
               gtt_ff   <= 44'(gt_ff) * 44'(t_ff);
               dx_ff    <= 26'(vxt_ff >>> 8);
               state_ff <= ST_PRE3;
            end
            ST_PRE3: begin
               dy_ff    <= 30'(dy_num >>> 16);
               state_ff <= ST_BOX;
            end
            ST_BOX: begin
               a_ff.lx  <= coord_type'(px_ff);
               a_ff.ly  <= coord_type'(py_ff);
               a_ff.hx  <= coord_type'(px_ff) + coord_type'(w_ff);
               a_ff.hy  <= coord_type'(py_ff) + coord_type'(h_ff);
               b_ff.lx  <= coord_type'(px_ff) + coord_type'(dx_ff);
               b_ff.ly  <= coord_type'(py_ff) + coord_type'(dy_ff);
               b_ff.hx  <= coord_type'(px_ff) + coord_type'(dx_ff) + coord_type'(w_ff);
               b_ff.hy  <= coord_type'(py_ff) + coord_type'(dy_ff) + coord_type'(h_ff);
               o_ff.lx  <= coord_type'(ox_ff);
               o_ff.ly  <= coord_type'(oy_ff);
               o_ff.hx  <= coord_type'(ox_ff) + coord_type'(ow_ff);
               o_ff.hy  <= coord_type'(oy_ff) + coord_type'(oh_ff);
               // Sweep quadrant from the sign of the displacement.
               if (dx_ff >= 0) quad_ff <= (dy_ff <= 0) ? 2'd0 : 2'd1;
               else            quad_ff <= (dy_ff >= 0) ? 2'd2 : 2'd3;
               state_ff <= ST_REJ;
            end
            ST_REJ: begin
               bis_ff  <= 1'b0;
               step_ff <= '0;
               if (reject) begin
                  res_hit_ff <= 1'b0;
                  res_x_ff   <= '0;
                  res_y_ff   <= '0;
                  state_ff   <= ST_DONE;
               end else begin
                  state_ff <= ST_LOAD;
               end
            end
            ST_MID: begin
               m_ff.lx  <= mid_x - half_w;
               m_ff.hx  <= mid_x + half_w;
               m_ff.ly  <= mid_y - half_h;
               m_ff.hy  <= mid_y + half_h;
               bis_ff   <= 1'b1;
               state_ff <= ST_LOAD;
            end
            ST_LOAD: begin
               for (int i = 0; i < 6; i++) hull_ff[i] <= hull_new[i];
               edge_ff  <= '0;
               state_ff <= ST_NORM;
            end
            ST_NORM: begin
               nx_ff    <= NORM_W'(edge_p.y) - NORM_W'(edge_n.y);
               ny_ff    <= NORM_W'(edge_n.x) - NORM_W'(edge_p.x);
               vtx_ff   <= '0;
               state_ff <= ST_DOT;
            end
            ST_DOT: begin
               p1_ff  <= PROD_W'(vtx_pt.x) * PROD_W'(nx_ff);
               p2_ff  <= PROD_W'(vtx_pt.y) * PROD_W'(ny_ff);
               pk_ff  <= vtx_ff;
               vtx_ff <= vtx_ff + 4'd1;
               if (vtx_ff == 4'd9) state_ff <= ST_DRAIN;
            end
            ST_DRAIN: begin
               state_ff <= ST_EVAL;
            end
            ST_EVAL: begin
               if (!separated && edge_ff != 3'd5) begin
                  edge_ff  <= edge_ff + 3'd1;
                  state_ff <= ST_NORM;
               end else if (!bis_ff) begin
                  // First test over the full sweep.
                  if (separated) begin
                     res_hit_ff <= 1'b0;
                     res_x_ff   <= '0;
                     res_y_ff   <= '0;
                     state_ff   <= ST_DONE;
                  end else begin
                     state_ff <= ST_MID;
                  end
               end else begin
                  // Keep the half that still hits.
                  if (separated) a_ff <= m_ff;
                  else           b_ff <= m_ff;
                  step_ff <= step_ff + 1'b1;
                  if (step_ff + 1'b1 == STEP_W'(BISECT_STEPS)) begin
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_MID;
                  end
               end
            end
            ST_DONE: begin
               // Hold until the output register is free.
               if (!rsp_valid_ff || !rsp_stall) begin
                  if (bis_ff) begin
                     rsp_hit_ff <= 1'b1;
                     rsp_x_ff   <= sat_x[23:0];
                     rsp_y_ff   <= sat_y[23:0];
                  end else begin
                     rsp_hit_ff <= res_hit_ff;
                     rsp_x_ff   <= res_x_ff;
                     rsp_y_ff   <= res_y_ff;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_contact_x = rsp_x_ff;
   assign rsp_contact_y = rsp_y_ff;

endmodule

/* test/tb_swept_box_sat_collision_unit.sv */
// Testbench for the swept box collision unit: directed and random sweeps checked by a predictor.
module tb_swept_box_sat_collision_unit;
   import sbsc_pkg::*;

   localparam int N_BISECT     = 10;
   localparam int IDLE_PCT     = 18;
   localparam int WATCHDOG_MAX = 8000;
   localparam int DRAIN_CYCLES = 1000;
   localparam int HOLD_CYCLES  = 2000;

   // One input beat, field for field as on the ports.
   typedef struct {
      logic signed [23:0] mx, my;
      logic [23:0]        mw, mh;
      logic signed [23:0] vx, vy;
      logic [9:0]         ticks;
      logic [1:0]         mode;
      logic signed [23:0] ox, oy;
      logic [23:0]        ow, oh;
   } sweep_item_type;

   // One result beat.
   typedef struct {
      logic               hit;
      logic signed [23:0] cx, cy;
   } contact_type;

   // Wide exact geometry for the predictor.
   typedef struct { longint x, y; } vtx_type;
   typedef struct { longint lx, ly, hx, hy; } rect_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               csr_wr_en         = 1'b0;
   logic [23:0]        csr_wr_data       = '0;
   logic               req_valid         = 1'b0;
   logic               req_stall;
   logic signed [23:0] req_mover_x       = '0;
   logic signed [23:0] req_mover_y       = '0;
   logic [23:0]        req_mover_w       = '0;
   logic [23:0]        req_mover_h       = '0;
   logic signed [23:0] req_vel_x         = '0;
   logic signed [23:0] req_vel_y         = '0;
   logic [9:0]         req_elapsed_ticks = '0;
   logic [1:0]         req_gravity_mode  = '0;
   logic signed [23:0] req_obstacle_x    = '0;
   logic signed [23:0] req_obstacle_y    = '0;
   logic [23:0]        req_obstacle_w    = '0;
   logic [23:0]        req_obstacle_h    = '0;
   logic               rsp_valid;
   logic               rsp_stall         = 1'b0;
   logic               rsp_hit;
   logic signed [23:0] rsp_contact_x;
   logic signed [23:0] rsp_contact_y;

   // Predictor copy of the gravity register.
   logic [23:0] gravity_reg = '0;
   contact_type contact_q[$];
   int          errors    = 0;
   int          hold_asks = 0;   // bumped by a test to request a long receiver hold-off
   int          hold_seen = 0;
   int          hold_left = 0;   // long receiver hold-off, counted by the stall process
   bit          calm      = 1'b0; // suppress random idling on both sides
   int          quiet_cycles = 0;

   swept_box_sat_collision_unit #(.BISECT_STEPS(N_BISECT)) u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mover_x       (req_mover_x),
      .req_mover_y       (req_mover_y),
      .req_mover_w       (req_mover_w),
      .req_mover_h       (req_mover_h),
      .req_vel_x         (req_vel_x),
      .req_vel_y         (req_vel_y),
      .req_elapsed_ticks (req_elapsed_ticks),
      .req_gravity_mode  (req_gravity_mode),
      .req_obstacle_x    (req_obstacle_x),
      .req_obstacle_y    (req_obstacle_y),
      .req_obstacle_w    (req_obstacle_w),
      .req_obstacle_h    (req_obstacle_h),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_contact_x     (rsp_contact_x),
      .rsp_contact_y     (rsp_contact_y)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   // Floor division, rounding toward minus infinity.
   function automatic longint floor_div(longint v, longint d);
      longint q;
      q = v / d;
      if ((v % d) != 0 && v < 0) q = q - 1;
      return q;
   endfunction

   function automatic vtx_type rect_corner(rect_type r, logic [1:0] code);
      vtx_type p;
      p.x = code[0] ? r.hx : r.lx;
      p.y = code[1] ? r.hy : r.ly;
      return p;
   endfunction

   // Six-point hull: slots 2..4 come from the end box, the rest from the start box.
   function automatic void sweep_hull(rect_type a, rect_type b, int quad, output vtx_type h[6]);
      for (int i = 0; i < 6; i++)
         h[i] = rect_corner((i >= 2 && i <= 4) ? b : a, CORNER_TAB[quad][i]);
   endfunction

   // Separating-axis test on the hull's edge normals only; touching counts as overlap.
   function automatic bit hull_meets_box(vtx_type h[6], vtx_type o[4]);
      longint nx, ny, d, lo1, hi1, lo2, hi2;
      for (int i = 0; i < 6; i++) begin
         nx = -(h[(i + 1) % 6].y - h[i].y);
         ny = h[(i + 1) % 6].x - h[i].x;
         for (int k = 0; k < 6; k++) begin
            d = h[k].x * nx + h[k].y * ny;
            if (k == 0 || d < lo1) lo1 = d;
            if (k == 0 || d > hi1) hi1 = d;
         end
         for (int k = 0; k < 4; k++) begin
            d = o[k].x * nx + o[k].y * ny;
            if (k == 0 || d < lo2) lo2 = d;
            if (k == 0 || d > hi2) hi2 = d;
         end
         if (hi1 < lo2 || lo1 > hi2) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic logic signed [23:0] clamp24(longint v);
      if (v > 8388607)  v = 8388607;
      if (v < -8388608) v = -8388608;
      return v[23:0];
   endfunction

   // Expected contact for one sweep under the current gravity setting.
   function automatic contact_type predict_contact(sweep_item_type it);
      contact_type r;
      longint      t, dir, dx, dy, hw, hh, mx, my;
      rect_type    a, b, o, m;
      vtx_type     hull[6], half[6], obs[4];
      int          quad;
      r.hit = 1'b0; r.cx = '0; r.cy = '0;
      t   = longint'(it.ticks);
      dir = (it.mode == GRAV_DOWN) ? 1 : ((it.mode == GRAV_UP) ? -1 : 0);
      dx  = floor_div(longint'(it.vx) * t, 256);
      dy  = floor_div(longint'(it.vy) * t * 256 + dir * longint'(gravity_reg) * t * t,
                      65536);
      a.lx = longint'(it.mx);  a.ly = longint'(it.my);
      a.hx = a.lx + longint'(it.mw);  a.hy = a.ly + longint'(it.mh);
      b.lx = a.lx + dx;  b.ly = a.ly + dy;
      b.hx = b.lx + longint'(it.mw);  b.hy = b.ly + longint'(it.mh);
      o.lx = longint'(it.ox);  o.ly = longint'(it.oy);
      o.hx = o.lx + longint'(it.ow);  o.hy = o.ly + longint'(it.oh);
      // quick reject on the sweep's bounding box
      if ((a.hy > b.hy ? a.hy : b.hy) < o.ly || (a.ly < b.ly ? a.ly : b.ly) > o.hy ||
          (a.hx > b.hx ? a.hx : b.hx) < o.lx || (a.lx < b.lx ? a.lx : b.lx) > o.hx)
         return r;
      if (dx >= 0) quad = (dy <= 0) ? 0 : 1;
      else         quad = (dy >= 0) ? 2 : 3;
      for (int k = 0; k < 4; k++) obs[k] = rect_corner(o, k[1:0]);
      sweep_hull(a, b, quad, hull);
      if (!hull_meets_box(hull, obs)) return r;
      hw = longint'(it.mw) / 2;
      hh = longint'(it.mh) / 2;
      // bisect: keep the half of the sweep that still meets the box
      for (int s = 0; s < N_BISECT; s++) begin
         mx = floor_div(hull[0].x + hull[3].x, 2);
         my = floor_div(hull[0].y + hull[3].y, 2);
         m.lx = mx - hw; m.hx = mx + hw;
         m.ly = my - hh; m.hy = my + hh;
         sweep_hull(a, m, quad, half);
         if (hull_meets_box(half, obs)) b = m;
         else                           a = m;
         sweep_hull(a, b, quad, hull);
      end
      r.hit = 1'b1;
      r.cx  = clamp24(a.lx);
      r.cy  = clamp24(a.ly);
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers

   // Send one beat; idle at random first, hold the payload until accepted.
   task automatic send_sweep(sweep_item_type it);
      if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_mover_x       <= it.mx;
      req_mover_y       <= it.my;
      req_mover_w       <= it.mw;
      req_mover_h       <= it.mh;
      req_vel_x         <= it.vx;
      req_vel_y         <= it.vy;
      req_elapsed_ticks <= it.ticks;
      req_gravity_mode  <= it.mode;
      req_obstacle_x    <= it.ox;
      req_obstacle_y    <= it.oy;
      req_obstacle_w    <= it.ow;
      req_obstacle_h    <= it.oh;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      contact_q = {contact_q, predict_contact(it)};
   endtask

   // Drop valid and hold until every expected contact has come back.
   task automatic drain_contacts();
      req_valid <= 1'b0;
      @(posedge clock);
      while (contact_q.size() != 0) @(posedge clock);
   endtask

   // Write the gravity register; only called with the unit idle.
   task automatic write_gravity(logic [23:0] g);
      drain_contacts();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= g;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      gravity_reg = g;
   endtask

   function automatic sweep_item_type make_sweep(int mx, int my, int mw, int mh, int vx,
                                                 int vy, int ticks, logic [1:0] mode,
                                                 int ox, int oy, int ow, int oh);
      sweep_item_type it;
      it.mx = 24'(mx); it.my = 24'(my); it.mw = 24'(mw); it.mh = 24'(mh);
      it.vx = 24'(vx); it.vy = 24'(vy); it.ticks = 10'(ticks); it.mode = mode;
      it.ox = 24'(ox); it.oy = 24'(oy); it.ow = 24'(ow); it.oh = 24'(oh);
      return it;
   endfunction

   // Random sweep: mostly aimed so the obstacle sits on the path, some pure noise.
   function automatic sweep_item_type random_sweep();
      sweep_item_type it;
      int             kind, vx, vy, t, ex, ey, frac;
      kind = $urandom_range(0, 99);
      it.mx = 24'($urandom); it.my = 24'($urandom); it.mw = 24'($urandom);
      it.mh = 24'($urandom); it.vx = 24'($urandom); it.vy = 24'($urandom);
      it.ticks = 10'($urandom);
      it.mode = 2'($urandom); it.ox = 24'($urandom); it.oy = 24'($urandom);
      it.ow = 24'($urandom); it.oh = 24'($urandom);
      if (kind < 20) return it;
      it.mx = 24'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      it.my = 24'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      it.mw = 24'($urandom_range(0, (kind < 30) ? 2 : 12000));
      it.mh = 24'($urandom_range(0, (kind < 30) ? 2 : 12000));
      if (kind < 85) begin
         vx = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
         vy = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
         it.vx = 24'(vx); it.vy = 24'(vy);
         it.ticks = 10'($urandom_range(0, 300));
      end
      t  = int'(it.ticks);
      ex = int'((longint'(it.vx) * t) >>> 8);
      ey = int'((longint'(it.vy) * t) >>> 8);
      frac = $urandom_range(0, 8);
      it.ox = 24'(int'(it.mx) + (ex * frac) / 8 + $signed($urandom_range(0, 8000)) - 4000);
      it.oy = 24'(int'(it.my) + (ey * frac) / 8 + $signed($urandom_range(0, 8000)) - 4000);
      it.ow = 24'($urandom_range(0, (kind < 40) ? 0 : 6000));
      it.oh = 24'($urandom_range(0, (kind < 40) ? 0 : 6000));
      return it;
   endfunction

   // ---------------------------------------------------------------- receiver

   // Hold off for a counted stretch when asked, otherwise stall at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_seen != hold_asks) begin
         hold_seen <= hold_asks;
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // Check each accepted result beat against the oldest expectation.
   always @(posedge clock) begin
      contact_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (contact_q.size() == 0) begin
            report_mismatch("unexpected beat, hit", longint'(rsp_hit), 0);
         end else begin
            want = contact_q.pop_front();
            if (rsp_hit !== want.hit)
               report_mismatch("hit", longint'(rsp_hit), longint'(want.hit));
            if (rsp_contact_x !== want.cx)
               report_mismatch("contact_x", longint'(rsp_contact_x), longint'(want.cx));
            if (rsp_contact_y !== want.cy)
               report_mismatch("contact_y", longint'(rsp_contact_y), longint'(want.cy));
         end
      end
   end

   // Watchdog: end the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_MAX) begin
         $display("watchdog: no beat for %0d cycles", quiet_cycles);
         $display("** swept_box_sat_collision_unit: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- tests

   // Field extremes, zero sizes, zero and full tick counts, saturating contact.
   task automatic test_extremes();
      write_gravity(24'd0);
      send_sweep(make_sweep(0, 0, 256, 256, 0, 0, 0, GRAV_NONE, 0, 0, 256, 256));
      send_sweep(make_sweep(0, 0, 0, 0, 0, 0, 0, GRAV_NONE, 0, 0, 0, 0));
      send_sweep(make_sweep(-8388608, -8388608, 0, 0, -8388608, -8388608, 1023, GRAV_NONE,
                            8388607, 8388607, 16777215, 16777215));
      send_sweep(make_sweep(8388607, 8388607, 16777215, 16777215, 8388607, 8388607, 1023,
                            GRAV_NONE, -8388608, -8388608, 16777215, 16777215));
      send_sweep(make_sweep(8388000, 0, 1000, 256, 8388607, 0, 1023, GRAV_NONE,
                            8388607, -100, 16777215, 1000));
      send_sweep(make_sweep(-8388000, 0, 256, 256, -8388608, 0, 1023, GRAV_NONE,
                            -8388608, 0, 300, 300));
      send_sweep(make_sweep(-1000, -1000, 16777215, 16777215, 100, -100, 1023, GRAV_NONE,
                            -8388608, -8388608, 0, 0));
   endtask

   // Every gravity mode, including the unused code, under the extreme settings.
   task automatic test_gravity_modes();
      write_gravity(24'hFFFFFF);
      for (int m = 0; m < 4; m++) begin
         send_sweep(make_sweep(0, 0, 512, 512, 65536, 0, 100, 2'(m), 20000, -4000, 2000,
                               8000));
         send_sweep(make_sweep(0, 0, 512, 512, 0, 0, 1023, 2'(m), -2000, 60000, 8000, 4000));
      end
      write_gravity(24'd1);
      send_sweep(make_sweep(0, 0, 512, 512, 0, -65536, 1023, GRAV_DOWN, -1000, -90000, 4000,
                            4000));
   endtask

   // Each sweep quadrant, a pure axis move, touching edges, and a hull miss.
   task automatic test_quadrants_touching();
      write_gravity(24'd0);
      send_sweep(make_sweep(0, 0, 256, 256, 65536, -65536, 10, GRAV_NONE, 1000, -1000, 500,
                            500));
      send_sweep(make_sweep(0, 0, 256, 256, 65536, 65536, 10, GRAV_NONE, 1000, 1000, 500,
                            500));
      send_sweep(make_sweep(0, 0, 256, 256, -65536, 65536, 10, GRAV_NONE, -1200, 1000, 500,
                            500));
      send_sweep(make_sweep(0, 0, 256, 256, -65536, -65536, 10, GRAV_NONE, -1200, -1200, 500,
                            500));
      send_sweep(make_sweep(0, 0, 256, 256, -65536, 0, 10, GRAV_NONE, -3000, 0, 256, 256));
      send_sweep(make_sweep(0, 0, 256, 256, 0, 0, 5, GRAV_NONE, 256, 256, 256, 256));
      send_sweep(make_sweep(0, 0, 256, 256, 0, 0, 5, GRAV_NONE, 257, 0, 256, 256));
      // diagonal sweep past a box sitting in the corner of its bounding box
      send_sweep(make_sweep(0, 0, 256, 256, 65536, 65536, 40, GRAV_NONE, 8000, 0, 1000, 1000));
      drain_contacts();
   endtask

   // Hold the receiver off while the sender keeps offering, then pause fully.
   task automatic test_backpressure();
      hold_asks++;
      for (int i = 0; i < 6; i++) send_sweep(random_sweep());
      drain_contacts();
   endtask

   // Random sweeps over several gravity settings, with a stretch of no idling.
   task automatic test_random(int count);
      logic [23:0] settings[4];
      settings[0] = 24'd0;
      settings[1] = 24'hFFFFFF;
      settings[2] = 24'($urandom_range(1, 255));
      settings[3] = 24'($urandom);
      for (int p = 0; p < 4; p++) begin
         write_gravity(settings[p]);
         calm = (p == 2);
         for (int i = 0; i < count / 4; i++) send_sweep(random_sweep());
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_gravity_modes();
      test_quadrants_touching();
      test_backpressure();
      test_random(840);
      drain_contacts();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && contact_q.size() == 0) begin
         $display("** swept_box_sat_collision_unit: PASSED **");
      end else begin
         $display("** swept_box_sat_collision_unit: FAILED **");
      end
      $finish;
   end

endmodule
